FILE: src/dnc_pkg.sv
// dnc_pkg: shared types and constants of the day number to calendar date block
// depends on nothing; used by the channel interfaces, the pipeline control and the top level
package dnc_pkg;

  // field widths of the channel words
  localparam int unsigned DATA_W   = 31;
  localparam int unsigned YEAR_W   = 23;
  localparam int unsigned CFG_IDX_W = 2;

  // pipeline depth, input register through output register
  localparam int unsigned NSTG = 11;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DATE_ALG = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRANULAR = 2'd1;

  // result status codes
  localparam logic [1:0] ST_RAW    = 2'd0;
  localparam logic [1:0] ST_DATE   = 2'd1;
  localparam logic [1:0] ST_BADCFG = 2'd2;

  // minute split: x / 1440 as (x >> 5) / 45, reciprocal of 45 scaled by 2^32
  localparam logic [26:0] DIV45_MUL     = 27'd95443718;
  localparam logic [10:0] MIN_PER_DAY   = 11'd1440;
  localparam logic [10:0] MIN_PER_HOUR  = 11'd60;
  // x / 60 for x < 1440, scaled by 2^16
  localparam logic [10:0] DIV60_MUL     = 11'd1093;

  // year estimate (10000 g + 14780) / 3652425, reduced by 5: (2000 g + 2956) / 730485
  localparam logic [41:0] YR_OFS = 42'd2956;
  localparam logic [19:0] YR_DIV = 20'd730485;
  // floor(2^51 / 730485), applied to the numerator shifted down by 10
  localparam logic [31:0] YR_MUL = 32'd3082609244;

  // x / 25 scaled by 2^26, for the century and 400-year terms
  localparam logic [21:0] DIV25_MUL = 22'd2684355;
  localparam logic [31:0] DAYS_PER_YEAR = 32'd365;

  // month index: x / 765 scaled by 2^26 (x is (100 ddd + 52) / 4)
  localparam logic [16:0] MI_MUL = 17'd87725;
  // x / 10 scaled by 2^16
  localparam logic [12:0] DIV10_MUL = 13'd6554;

  // fields that travel along the pipeline with each word
  typedef struct packed {
    logic [DATA_W-1:0] event_tag;
    logic [DATA_W-1:0] period_num;
    logic [DATA_W-1:0] date_id;
    logic [1:0]        status;
    logic              conv;
    logic              gran;
    logic [4:0]        hour;
    logic [5:0]        minute;
  } carry_t;

  // one result word
  typedef struct packed {
    logic [DATA_W-1:0] event_out;
    logic [DATA_W-1:0] period_out;
    logic [DATA_W-1:0] raw_date;
    logic [YEAR_W-1:0] year;
    logic [3:0]        month;
    logic [4:0]        day;
    logic [4:0]        hour;
    logic [5:0]        minute;
    logic [1:0]        status;
  } res_t;

  // per-stage load enables and valid bits
  typedef struct packed {
    logic [NSTG-1:0] en;
    logic [NSTG-1:0] vld;
  } pipe_ctl_t;

endpackage

FILE: src/dnc_in_if.sv
// dnc_in_if: input channel carrying one occurrence record per word
// depends on dnc_pkg for field widths
interface dnc_in_if;
  logic                       valid;
  logic                       ready;
  logic [dnc_pkg::DATA_W-1:0] event_tag;
  logic [dnc_pkg::DATA_W-1:0] period_num;
  logic [dnc_pkg::DATA_W-1:0] date_id;

  modport source (output valid, event_tag, period_num, date_id, input ready);
  modport sink   (input valid, event_tag, period_num, date_id, output ready);
endinterface

FILE: src/dnc_out_if.sv
// dnc_out_if: result channel carrying one converted record per word
// depends on dnc_pkg for field widths
interface dnc_out_if;
  logic                       valid;
  logic                       ready;
  logic [dnc_pkg::DATA_W-1:0] event_out;
  logic [dnc_pkg::DATA_W-1:0] period_out;
  logic [dnc_pkg::DATA_W-1:0] raw_date;
  logic [dnc_pkg::YEAR_W-1:0] year;
  logic [3:0]                 month;
  logic [4:0]                 day;
  logic [4:0]                 hour;
  logic [5:0]                 minute;
  logic [1:0]                 status;

  modport source (output valid, event_out, period_out, raw_date, year, month, day, hour,
                  minute, status, input ready);
  modport sink   (input valid, event_out, period_out, raw_date, year, month, day, hour,
                  minute, status, output ready);
endinterface

FILE: src/dnc_cfg_if.sv
// dnc_cfg_if: configuration write channel, register index and write data
// depends on dnc_pkg for the index width
interface dnc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [dnc_pkg::CFG_IDX_W-1:0] index;
  logic                          data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/dnc_pipe_ctl.sv
// dnc_pipe_ctl: valid bits and load enables of the conversion pipeline
// depends on dnc_pkg (NSTG, pipe_ctl_t)
module dnc_pipe_ctl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               out_ready,
  output dnc_pkg::pipe_ctl_t ctl
);

  logic [dnc_pkg::NSTG-1:0] vld_r, vld_nxt;
  logic [dnc_pkg::NSTG-1:0] en;

  // a stage loads when it is empty or the stage after it loads too
  always_comb begin
    en[dnc_pkg::NSTG-1] = !vld_r[dnc_pkg::NSTG-1] || out_ready;
    for (int k = dnc_pkg::NSTG - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  always_comb begin
    vld_nxt[0] = en[0] ? in_valid : vld_r[0];
    for (int k = 1; k < dnc_pkg::NSTG; k++) begin
      vld_nxt[k] = en[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign ctl.en  = en;
  assign ctl.vld = vld_r;

endmodule

FILE: src/day_number_to_calendar_date_top.sv
// day_number_to_calendar_date_top: streaming day number to Gregorian date converter
// depends on dnc_pkg, dnc_in_if, dnc_out_if, dnc_cfg_if and dnc_pipe_ctl
//
// usage:
//   in_ch takes one occurrence word (event id, period number, date id) per cycle while
//   in_ch.ready is high; out_ch gives one result word per input word, in input order
//   cfg_ch writes date_algorithm (index 0) and granular (index 1), low data bit;
//   it is always ready and must only be used while no word is in flight
//   with date_algorithm set the date id becomes year, month and day; with granular
//   also set the date id counts minutes and hour and minute are filled in;
//   granular without date_algorithm returns a bad configuration status
// depth and throughput:
//   eleven register stages, with about one wide multiply per stage in the minute split,
//   year estimate and month steps; one word per cycle sustained while out_ch is ready,
//   since each stage loads whenever the stage after it loads
// reset: rst_n (synchronous, active low) empties the pipeline and clears both
//   configuration registers
// stall: when out_ch is not ready, words keep entering until every stage is
//   full; holes in the pipeline close up, nothing is dropped or repeated
module day_number_to_calendar_date_top (
  input logic       clk,
  input logic       rst_n,
  dnc_in_if.sink    in_ch,
  dnc_out_if.source out_ch,
  dnc_cfg_if.sink   cfg_ch
);

  // configuration registers
  logic alg_r, alg_nxt;
  logic gran_r, gran_nxt;

  // pipeline control
  dnc_pkg::pipe_ctl_t ctl;

  // stage 1: capture, minute split multiply
  dnc_pkg::carry_t s1_c_r, s1_c_nxt;
  logic [20:0]     s1_days_r, s1_days_nxt;
  logic [52:0]     p1;

  // stage 2: day number select, minute of day, year numerator
  dnc_pkg::carry_t s2_c_r, s2_c_nxt;
  logic [30:0]     s2_g_r, s2_g_nxt;
  logic [10:0]     s2_rem_r, s2_rem_nxt;
  logic [41:0]     s2_n_r, s2_n_nxt;

  // stage 3: year estimate, hour
  dnc_pkg::carry_t s3_c_r, s3_c_nxt;
  logic [30:0]     s3_g_r, s3_g_nxt;
  logic [10:0]     s3_rem_r, s3_rem_nxt;
  logic [41:0]     s3_n_r, s3_n_nxt;
  logic [22:0]     s3_q_r, s3_q_nxt;
  logic [63:0]     p3;
  logic [21:0]     ph;

  // stage 4: estimate back-multiply, minute
  dnc_pkg::carry_t s4_c_r, s4_c_nxt;
  logic [30:0]     s4_g_r, s4_g_nxt;
  logic [41:0]     s4_n_r, s4_n_nxt;
  logic [22:0]     s4_q_r, s4_q_nxt;
  logic [41:0]     s4_t_r, s4_t_nxt;
  logic [10:0]     m11;

  // stage 5: exact year estimate
  dnc_pkg::carry_t s5_c_r, s5_c_nxt;
  logic [30:0]     s5_g_r, s5_g_nxt;
  logic [22:0]     s5_y_r, s5_y_nxt;
  logic [41:0]     r5;

  // stage 6: century and 400-year counts
  dnc_pkg::carry_t s6_c_r, s6_c_nxt;
  logic [30:0]     s6_g_r, s6_g_nxt;
  logic [22:0]     s6_y_r, s6_y_nxt;
  logic [16:0]     s6_cen_r, s6_cen_nxt;
  logic [14:0]     s6_qc_r, s6_qc_nxt;
  logic [42:0]     pc;
  logic [40:0]     pf;

  // stage 7: days before year, leap flag
  dnc_pkg::carry_t s7_c_r, s7_c_nxt;
  logic [30:0]     s7_g_r, s7_g_nxt;
  logic [22:0]     s7_y_r, s7_y_nxt;
  logic [31:0]     s7_dby_r, s7_dby_nxt;
  logic            s7_leap_r, s7_leap_nxt;

  // stage 8: day of year with one-year correction
  dnc_pkg::carry_t s8_c_r, s8_c_nxt;
  logic [22:0]     s8_y_r, s8_y_nxt;
  logic [9:0]      s8_ddd_r, s8_ddd_nxt;
  logic [32:0]     d8, dd8;

  // stage 9: month index
  dnc_pkg::carry_t s9_c_r, s9_c_nxt;
  logic [22:0]     s9_y_r, s9_y_nxt;
  logic [9:0]      s9_ddd_r, s9_ddd_nxt;
  logic [5:0]      s9_mi_r, s9_mi_nxt;
  logic [16:0]     n9;
  logic [31:0]     p9;

  // stage 10: month, year carry, month start day
  dnc_pkg::carry_t s10_c_r, s10_c_nxt;
  logic [22:0]     s10_y_r, s10_y_nxt;
  logic [9:0]      s10_ddd_r, s10_ddd_nxt;
  logic [3:0]      s10_mo_r, s10_mo_nxt;
  logic [4:0]      s10_ms_r, s10_ms_nxt;
  logic [5:0]      t10;
  logic [5:0]      tm10;
  logic [1:0]      yadd10;
  logic [14:0]     v10;
  logic [27:0]     p10;

  // stage 11: output register
  dnc_pkg::res_t   out_r, out_nxt;

  // ---------------------------------------------------------------------------
  // configuration port, always ready; only the low data bit is kept
  // ---------------------------------------------------------------------------
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    alg_nxt  = alg_r;
    gran_nxt = gran_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        dnc_pkg::CFG_DATE_ALG: alg_nxt  = cfg_ch.data;
        dnc_pkg::CFG_GRANULAR: gran_nxt = cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alg_r  <= 1'b0;
      gran_r <= 1'b0;
    end else begin
      alg_r  <= alg_nxt;
      gran_r <= gran_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // valid bits and load enables
  // ---------------------------------------------------------------------------
  dnc_pipe_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .out_ready (out_ch.ready),
    .ctl       (ctl)
  );

  assign in_ch.ready = ctl.en[0];

  // ---------------------------------------------------------------------------
  // stage 1: mode is sampled with the word; whole days = (date_id >> 5) / 45
  // ---------------------------------------------------------------------------
  always_comb begin
    s1_c_nxt.event_tag  = in_ch.event_tag;
    s1_c_nxt.period_num = in_ch.period_num;
    s1_c_nxt.date_id    = in_ch.date_id;
    s1_c_nxt.conv       = alg_r;
    s1_c_nxt.gran       = gran_r;
    s1_c_nxt.hour       = 5'd0;
    s1_c_nxt.minute     = 6'd0;
    if (!alg_r) begin
      s1_c_nxt.status = gran_r ? dnc_pkg::ST_BADCFG : dnc_pkg::ST_RAW;
    end else begin
      s1_c_nxt.status = dnc_pkg::ST_DATE;
    end
    p1          = 53'(in_ch.date_id[30:5]) * 53'(dnc_pkg::DIV45_MUL);
    s1_days_nxt = p1[52:32];
  end

  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      s1_c_r    <= s1_c_nxt;
      s1_days_r <= s1_days_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: pick the day number, minute of day, numerator 2000 g + 2956
  // ---------------------------------------------------------------------------
  always_comb begin
    s2_c_nxt   = s1_c_r;
    s2_g_nxt   = s1_c_r.gran ? 31'(s1_days_r) : s1_c_r.date_id;
    // remainder is below 1440, so the low 11 bits are enough
    s2_rem_nxt = s1_c_r.date_id[10:0] - s1_days_r[10:0] * dnc_pkg::MIN_PER_DAY;
    s2_n_nxt   = (42'(s2_g_nxt) << 11) - (42'(s2_g_nxt) << 5) - (42'(s2_g_nxt) << 4)
                 + dnc_pkg::YR_OFS;
  end

  always_ff @(posedge clk) begin
    if (ctl.en[1]) begin
      s2_c_r   <= s2_c_nxt;
      s2_g_r   <= s2_g_nxt;
      s2_rem_r <= s2_rem_nxt;
      s2_n_r   <= s2_n_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: year estimate, low by at most one; hour of day
  // ---------------------------------------------------------------------------
  always_comb begin
    s3_c_nxt      = s2_c_r;
    s3_g_nxt      = s2_g_r;
    s3_rem_nxt    = s2_rem_r;
    s3_n_nxt      = s2_n_r;
    p3            = 64'(s2_n_r[41:10]) * 64'(dnc_pkg::YR_MUL);
    s3_q_nxt      = p3[63:41];
    ph            = 22'(s2_rem_r) * 22'(dnc_pkg::DIV60_MUL);
    s3_c_nxt.hour = ph[20:16];
  end

  always_ff @(posedge clk) begin
    if (ctl.en[2]) begin
      s3_c_r   <= s3_c_nxt;
      s3_g_r   <= s3_g_nxt;
      s3_rem_r <= s3_rem_nxt;
      s3_n_r   <= s3_n_nxt;
      s3_q_r   <= s3_q_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 4: estimate times divisor; minute of hour
  // ---------------------------------------------------------------------------
  always_comb begin
    s4_c_nxt        = s3_c_r;
    s4_g_nxt        = s3_g_r;
    s4_n_nxt        = s3_n_r;
    s4_q_nxt        = s3_q_r;
    s4_t_nxt        = 42'(s3_q_r) * 42'(dnc_pkg::YR_DIV);
    m11             = s3_rem_r - 11'(s3_c_r.hour) * dnc_pkg::MIN_PER_HOUR;
    s4_c_nxt.minute = m11[5:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.en[3]) begin
      s4_c_r <= s4_c_nxt;
      s4_g_r <= s4_g_nxt;
      s4_n_r <= s4_n_nxt;
      s4_q_r <= s4_q_nxt;
      s4_t_r <= s4_t_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 5: remainder check fixes the estimate to the exact quotient
  // ---------------------------------------------------------------------------
  always_comb begin
    s5_c_nxt = s4_c_r;
    s5_g_nxt = s4_g_r;
    r5       = s4_n_r - s4_t_r;
    s5_y_nxt = (r5 >= 42'(dnc_pkg::YR_DIV)) ? s4_q_r + 23'd1 : s4_q_r;
  end

  always_ff @(posedge clk) begin
    if (ctl.en[4]) begin
      s5_c_r <= s5_c_nxt;
      s5_g_r <= s5_g_nxt;
      s5_y_r <= s5_y_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 6: y / 100 = (y >> 2) / 25, y / 400 = (y >> 4) / 25
  // ---------------------------------------------------------------------------
  always_comb begin
    s6_c_nxt   = s5_c_r;
    s6_g_nxt   = s5_g_r;
    s6_y_nxt   = s5_y_r;
    pc         = 43'(s5_y_r[22:2]) * 43'(dnc_pkg::DIV25_MUL);
    pf         = 41'(s5_y_r[22:4]) * 41'(dnc_pkg::DIV25_MUL);
    s6_cen_nxt = pc[42:26];
    s6_qc_nxt  = pf[40:26];
  end

  always_ff @(posedge clk) begin
    if (ctl.en[5]) begin
      s6_c_r   <= s6_c_nxt;
      s6_g_r   <= s6_g_nxt;
      s6_y_r   <= s6_y_nxt;
      s6_cen_r <= s6_cen_nxt;
      s6_qc_r  <= s6_qc_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 7: days before the march-based year; leap flag of calendar year y,
  // which is the length of the year before it less 365
  // ---------------------------------------------------------------------------
  always_comb begin
    s7_c_nxt    = s6_c_r;
    s7_g_nxt    = s6_g_r;
    s7_y_nxt    = s6_y_r;
    s7_dby_nxt  = 32'(s6_y_r) * dnc_pkg::DAYS_PER_YEAR + 32'(s6_y_r[22:2])
                  - 32'(s6_cen_r) + 32'(s6_qc_r);
    s7_leap_nxt = (s6_y_r[1:0] == 2'b00) &&
                  ((24'(s6_cen_r) * 24'd100 != 24'(s6_y_r)) ||
                   (24'(s6_qc_r) * 24'd400 == 24'(s6_y_r)));
  end

  always_ff @(posedge clk) begin
    if (ctl.en[6]) begin
      s7_c_r    <= s7_c_nxt;
      s7_g_r    <= s7_g_nxt;
      s7_y_r    <= s7_y_nxt;
      s7_dby_r  <= s7_dby_nxt;
      s7_leap_r <= s7_leap_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 8: day of year; a negative value steps back one year
  // ---------------------------------------------------------------------------
  always_comb begin
    s8_c_nxt = s7_c_r;
    d8       = 33'(s7_g_r) - 33'(s7_dby_r);
    dd8      = d8 + 33'(dnc_pkg::DAYS_PER_YEAR) + 33'(s7_leap_r);
    if (d8[32]) begin
      s8_y_nxt   = s7_y_r - 23'd1;
      s8_ddd_nxt = dd8[9:0];
    end else begin
      s8_y_nxt   = s7_y_r;
      s8_ddd_nxt = d8[9:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[7]) begin
      s8_c_r   <= s8_c_nxt;
      s8_y_r   <= s8_y_nxt;
      s8_ddd_r <= s8_ddd_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 9: month index (100 ddd + 52) / 3060, march is 0
  // ---------------------------------------------------------------------------
  always_comb begin
    s9_c_nxt   = s8_c_r;
    s9_y_nxt   = s8_y_r;
    s9_ddd_nxt = s8_ddd_r;
    n9         = 17'(s8_ddd_r) * 17'd100 + 17'd52;
    p9         = 32'(n9[16:2]) * 32'(dnc_pkg::MI_MUL);
    s9_mi_nxt  = p9[31:26];
  end

  always_ff @(posedge clk) begin
    if (ctl.en[8]) begin
      s9_c_r   <= s9_c_nxt;
      s9_y_r   <= s9_y_nxt;
      s9_ddd_r <= s9_ddd_nxt;
      s9_mi_r  <= s9_mi_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 10: calendar month, january and february roll into the next year,
  // first day of the month (mi * 306 + 5) / 10
  // ---------------------------------------------------------------------------
  always_comb begin
    s10_c_nxt   = s9_c_r;
    s10_ddd_nxt = s9_ddd_r;
    t10         = s9_mi_r + 6'd2;
    if (t10 >= 6'd24) begin
      tm10   = t10 - 6'd24;
      yadd10 = 2'd2;
    end else if (t10 >= 6'd12) begin
      tm10   = t10 - 6'd12;
      yadd10 = 2'd1;
    end else begin
      tm10   = t10;
      yadd10 = 2'd0;
    end
    s10_mo_nxt = tm10[3:0] + 4'd1;
    s10_y_nxt  = s9_y_r + 23'(yadd10);
    v10        = 15'(s9_mi_r) * 15'd306 + 15'd5;
    p10        = 28'(v10) * 28'(dnc_pkg::DIV10_MUL);
    s10_ms_nxt = p10[20:16];
  end

  always_ff @(posedge clk) begin
    if (ctl.en[9]) begin
      s10_c_r   <= s10_c_nxt;
      s10_y_r   <= s10_y_nxt;
      s10_ddd_r <= s10_ddd_nxt;
      s10_mo_r  <= s10_mo_nxt;
      s10_ms_r  <= s10_ms_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 11: day of month and result assembly; fields not produced by the
  // selected mode read as zero
  // ---------------------------------------------------------------------------
  always_comb begin
    out_nxt.event_out  = s10_c_r.event_tag;
    out_nxt.period_out = s10_c_r.period_num;
    out_nxt.raw_date   = s10_c_r.date_id;
    out_nxt.status     = s10_c_r.status;
    if (s10_c_r.conv) begin
      out_nxt.year  = s10_y_r;
      out_nxt.month = s10_mo_r;
      out_nxt.day   = s10_ddd_r[4:0] - s10_ms_r + 5'd1;
    end else begin
      out_nxt.year  = '0;
      out_nxt.month = '0;
      out_nxt.day   = '0;
    end
    if (s10_c_r.conv && s10_c_r.gran) begin
      out_nxt.hour   = s10_c_r.hour;
      out_nxt.minute = s10_c_r.minute;
    end else begin
      out_nxt.hour   = '0;
      out_nxt.minute = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[dnc_pkg::NSTG-1]) begin
      out_r <= out_nxt;
    end
  end

  // result channel
  assign out_ch.valid      = ctl.vld[dnc_pkg::NSTG-1];
  assign out_ch.event_out  = out_r.event_out;
  assign out_ch.period_out = out_r.period_out;
  assign out_ch.raw_date   = out_r.raw_date;
  assign out_ch.year       = out_r.year;
  assign out_ch.month      = out_r.month;
  assign out_ch.day        = out_r.day;
  assign out_ch.hour       = out_r.hour;
  assign out_ch.minute     = out_r.minute;
  assign out_ch.status     = out_r.status;

endmodule

FILE: tb/testbench.sv
// testbench: self-checking bench for day_number_to_calendar_date_top, directed table then
// random phases with bursty input, stalling output and configuration changes between phases
// depends on dnc_pkg, dnc_in_if, dnc_out_if, dnc_cfg_if and the top level in src
module testbench;
  import dnc_pkg::*;

  // spare register index, writes to it must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd2;
  localparam logic [DATA_W-1:0]    DATE_MAX  = '1;
  localparam int                   RANDOM_WORDS = 400;

  logic clk = 1'b0;
  logic rst_n;

  always #1 clk = ~clk;

  dnc_in_if  in_ch ();
  dnc_out_if out_ch ();
  dnc_cfg_if cfg_ch ();

  day_number_to_calendar_date_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // one row of the directed table; want is used only where typed is set
  typedef struct {
    bit                alg;
    bit                gran;
    logic [DATA_W-1:0] ev;
    logic [DATA_W-1:0] pn;
    logic [DATA_W-1:0] dt;
    bit                typed;
    res_t              want;
  } date_row_t;

  date_row_t date_table[$];
  res_t      pending_dates[$];  // expected result words, oldest first
  int        mismatch_count = 0;
  int        burst_left = 0;

  // shadow of the two configuration registers
  bit alg_en  = 1'b0;
  bit gran_en = 1'b0;

  // ---------------------------------------------------------------------------
  // calendar arithmetic
  // ---------------------------------------------------------------------------

  // days from the start of year 0 (march based) to the start of year y
  function automatic longint days_to_year(longint y);
    return 365 * y + y / 4 - y / 100 + y / 400;
  endfunction

  // expected result word for one record under the given settings
  function automatic res_t calendar_of(logic [DATA_W-1:0] ev, logic [DATA_W-1:0] pn,
                                       logic [DATA_W-1:0] dt, bit alg, bit gran);
    res_t   r;
    longint g, y, ddd, mi, mins;
    r            = '0;
    r.event_out  = ev;
    r.period_out = pn;
    r.raw_date   = dt;
    if (!alg) begin
      // passthrough, or the bad combination granular without conversion
      r.status = gran ? ST_BADCFG : ST_RAW;
      return r;
    end
    g    = longint'(dt);
    mins = 0;
    if (gran) begin
      mins = g % longint'(MIN_PER_DAY);
      g    = g / longint'(MIN_PER_DAY);
    end
    // estimate the year, step back one if the estimate overshoots
    y   = (10000 * g + 14780) / 3652425;
    ddd = g - days_to_year(y);
    if (ddd < 0) begin
      y   = y - 1;
      ddd = g - days_to_year(y);
    end
    // month index counted from march, january and february roll into the next year
    mi       = (100 * ddd + 52) / 3060;
    r.month  = 4'((mi + 2) % 12 + 1);
    r.year   = YEAR_W'(y + (mi + 2) / 12);
    r.day    = 5'(ddd - (mi * 306 + 5) / 10 + 1);
    r.hour   = 5'(mins / longint'(MIN_PER_HOUR));
    r.minute = 6'(mins % longint'(MIN_PER_HOUR));
    r.status = ST_DATE;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic add_row(bit alg, bit gran, logic [DATA_W-1:0] ev, logic [DATA_W-1:0] pn,
                         logic [DATA_W-1:0] dt, bit typed, int yr, int mo, int dy,
                         int hr, int mn, logic [1:0] st);
    date_row_t row;
    row.alg  = alg;
    row.gran = gran;
    row.ev   = ev;
    row.pn   = pn;
    row.dt   = dt;
    row.typed = typed;
    row.want = '{event_out: ev, period_out: pn, raw_date: dt, year: YEAR_W'(yr),
                 month: 4'(mo), day: 5'(dy), hour: 5'(hr), minute: 6'(mn), status: st};
    date_table.push_back(row);
  endtask

  // random date id, weighted toward small values, the top of the range and year starts
  function automatic logic [DATA_W-1:0] pick_date(bit gran);
    longint v;
    longint y;
    case ($urandom_range(0, 5))
      0: v = longint'(DATA_W'($urandom));
      1: v = $urandom_range(0, 3000);
      2: v = $urandom_range(0, 1 << 22);
      3: v = longint'(DATE_MAX) - $urandom_range(0, 5000);
      default: begin
        // a few days around a year start, often a century or 400-year start
        if (gran) y = $urandom_range(0, 4000);
        else      y = $urandom_range(0, 5879000);
        if ($urandom_range(0, 1)) y = y - y % (($urandom_range(0, 1)) ? 400 : 100);
        v = days_to_year(y) + $urandom_range(0, 4) - 2;
        if (v < 0) v = 0;
        if (gran) v = v * longint'(MIN_PER_DAY) + $urandom_range(0, 1439);
        if (v > longint'(DATE_MAX)) v = longint'(DATE_MAX);
      end
    endcase
    return DATA_W'(v);
  endfunction

  function automatic logic [DATA_W-1:0] pick_tag();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return DATE_MAX;
      default: return DATA_W'($urandom);
    endcase
  endfunction

  // offer one word; between bursts of random length the sender may idle
  task automatic send_record(logic [DATA_W-1:0] ev, logic [DATA_W-1:0] pn,
                             logic [DATA_W-1:0] dt, bit typed, res_t want);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_ch.valid      <= 1'b1;
    in_ch.event_tag  <= ev;
    in_ch.period_num <= pn;
    in_ch.date_id    <= dt;
    do @(posedge clk); while (!in_ch.ready);
    // word taken at this edge under the current settings
    if (typed) pending_dates.push_back(want);
    else       pending_dates.push_back(calendar_of(ev, pn, dt, alg_en, gran_en));
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, bit val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      CFG_DATE_ALG: alg_en  = val;
      CFG_GRANULAR: gran_en = val;
      default: ;
    endcase
  endtask

  // stop sending and let every word in flight come out
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (NSTG + 2) @(posedge clk);
  endtask

  task automatic set_mode(bit alg, bit gran);
    drain();
    write_reg(CFG_DATE_ALG, alg);
    if ($urandom_range(0, 1)) write_reg(CFG_SPARE, 1'($urandom));
    write_reg(CFG_GRANULAR, gran);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic report(string what);
    if (mismatch_count < 100) $display("mismatch: %s", what);
    mismatch_count++;
  endtask

  task automatic check_field(string name, longint got, longint want);
    if (got != want)
      report($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // ---------------------------------------------------------------------------
  // sender: reset, directed table, random phases, end of run
  // ---------------------------------------------------------------------------
  initial begin
    int   sent;
    int   n;
    bit   alg;
    bit   gran;
    res_t none;
    none = '0;

    // every input known from the start
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.event_tag  <= '0;
    in_ch.period_num <= '0;
    in_ch.date_id    <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= CFG_DATE_ALG;
    cfg_ch.data      <= 1'b0;

    // reset settings: raw passthrough, all date fields zero
    add_row(0, 0, DATE_MAX, '0, DATE_MAX, 1, 0, 0, 0, 0, 0, ST_RAW);
    add_row(0, 0, '0, DATE_MAX, '0, 1, 0, 0, 0, 0, 0, ST_RAW);
    // granular without conversion is flagged, tags still copied
    add_row(0, 1, DATE_MAX, DATE_MAX, DATE_MAX, 1, 0, 0, 0, 0, 0, ST_BADCFG);
    add_row(0, 1, '0, '0, '0, 1, 0, 0, 0, 0, 0, ST_BADCFG);
    // day zero is march 1 of year 0; last day of that year and first of the next
    add_row(1, 0, 31'd1, 31'd2, 31'd0, 1, 0, 3, 1, 0, 0, ST_DATE);
    add_row(1, 0, 31'd3, 31'd4, 31'd305, 1, 0, 12, 31, 0, 0, ST_DATE);
    add_row(1, 0, 31'd5, 31'd6, 31'd306, 1, 1, 1, 1, 0, 0, ST_DATE);
    // leap days, century and 400-year edges, largest day number
    add_row(1, 0, 31'd7, 31'd8, 31'd59, 0, 0, 0, 0, 0, 0, ST_DATE);
    add_row(1, 0, 31'd9, 31'd10, 31'd36523, 0, 0, 0, 0, 0, 0, ST_DATE);
    add_row(1, 0, 31'd11, 31'd12, 31'd36524, 0, 0, 0, 0, 0, 0, ST_DATE);
    add_row(1, 0, 31'd13, 31'd14, 31'd146096, 0, 0, 0, 0, 0, 0, ST_DATE);
    add_row(1, 0, 31'd15, 31'd16, 31'd146097, 0, 0, 0, 0, 0, 0, ST_DATE);
    add_row(1, 0, 31'd17, 31'd18, 31'd730484, 0, 0, 0, 0, 0, 0, ST_DATE);
    add_row(1, 0, 31'd19, 31'd20, 31'd730485, 0, 0, 0, 0, 0, 0, ST_DATE);
    add_row(1, 0, 31'h2AAAAAAA, 31'h55555555, 31'h40000000, 0, 0, 0, 0, 0, 0, ST_DATE);
    add_row(1, 0, DATE_MAX, DATE_MAX, DATE_MAX, 0, 0, 0, 0, 0, 0, ST_DATE);
    // minute counts: first minute, last minute of day zero, first of day one
    add_row(1, 1, 31'd21, 31'd22, 31'd0, 1, 0, 3, 1, 0, 0, ST_DATE);
    add_row(1, 1, 31'd23, 31'd24, 31'd1439, 1, 0, 3, 1, 23, 59, ST_DATE);
    add_row(1, 1, 31'd25, 31'd26, 31'd1440, 1, 0, 3, 2, 0, 0, ST_DATE);
    add_row(1, 1, 31'd27, 31'd28, 31'd1051899154, 0, 0, 0, 0, 0, 0, ST_DATE);
    add_row(1, 1, 31'h55555555, 31'h2AAAAAAA, 31'h55555555, 0, 0, 0, 0, 0, 0, ST_DATE);
    add_row(1, 1, DATE_MAX, '0, DATE_MAX, 0, 0, 0, 0, 0, 0, ST_DATE);
    // back to passthrough after conversion
    add_row(0, 0, 31'd29, 31'd30, 31'd123456, 0, 0, 0, 0, 0, 0, ST_RAW);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, settings change only between rows where the table asks
    foreach (date_table[i]) begin
      if (date_table[i].alg != alg_en || date_table[i].gran != gran_en)
        set_mode(date_table[i].alg, date_table[i].gran);
      send_record(date_table[i].ev, date_table[i].pn, date_table[i].dt,
                  date_table[i].typed, date_table[i].want);
    end

    // random phases, conversion on in most of them
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      alg  = ($urandom_range(0, 3) != 0);
      gran = ($urandom_range(0, 2) == 0);
      set_mode(alg, gran);
      n = $urandom_range(20, 90);
      repeat (n) send_record(pick_tag(), pick_tag(), pick_date(gran), 0, none);
      sent += n;
    end

    // wait for the last words, then a margin for anything spurious
    drain();
    repeat (4 * NSTG) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // receiver: stall pattern of its own, with a long hold-off every few segments
  // so the pipeline fills and pushes back on the sender
  // ---------------------------------------------------------------------------
  initial begin
    int seg;
    int len;
    int mode;
    seg = 0;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      seg++;
      if (seg % 7 == 3) begin
        out_ch.ready <= 1'b0;
        len = $urandom_range(40, 80);
        repeat (len) @(posedge clk);
      end else begin
        mode = $urandom_range(0, 2);
        len  = $urandom_range(5, 40);
        repeat (len) begin
          case (mode)
            0:       out_ch.ready <= 1'b1;
            1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
            default: out_ch.ready <= ($urandom_range(0, 3) == 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result check, one word per handshake against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_dates.size() == 0) begin
        report($sformatf("result word with no expectation, raw_date %0d", out_ch.raw_date));
      end else begin
        want = pending_dates.pop_front();
        check_field("event_out", longint'(out_ch.event_out), longint'(want.event_out));
        check_field("period_out", longint'(out_ch.period_out), longint'(want.period_out));
        check_field("raw_date", longint'(out_ch.raw_date), longint'(want.raw_date));
        check_field("year", longint'(out_ch.year), longint'(want.year));
        check_field("month", longint'(out_ch.month), longint'(want.month));
        check_field("day", longint'(out_ch.day), longint'(want.day));
        check_field("hour", longint'(out_ch.hour), longint'(want.hour));
        check_field("minute", longint'(out_ch.minute), longint'(want.minute));
        check_field("status", longint'(out_ch.status), longint'(want.status));
      end
    end
  end

  // hard stop if the run hangs
  initial begin
    #400000;
    $display("Verification failed");
    $finish;
  end

endmodule
